/* hw/rtl/pfx_eval_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Sequencer states, status codes and character codes for the postfix
// expression evaluator.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_OVERFLOW  = 3'd1,
      STAT_UNDERFLOW = 3'd2,
      STAT_INVALID   = 3'd3,
      STAT_DIVZERO   = 3'd4
   } status_type;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

endpackage
`default_nettype wire

/* hw/rtl/postfix_expression_evaluator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Stack machine that evaluates a postfix expression one character per word,
// with a shared 33-bit adder that serves add, subtract, shift-add multiply
// and restoring divide.
// ----------------------------------------------------------------------------
// Each accepted word carries one ASCII character; each gives exactly one
// result word with the top of stack (0 when empty), the sticky status and a
// copy of the last flag. Digits push, + - * / pop two and push op1 op op2 in
// wrapping 32-bit two's complement, division truncating toward zero. Any
// fault latches a status that freezes the stack until the word marked last,
// after which stack and status are cleared. The block takes one word at a
// time: a digit, an invalid character or any word under a latched fault goes
// from decode straight to finish, + and - pass through exec and write, * and
// / iterate in the multiply and divide states, a negative quotient then has
// a fix step (a division by zero goes from exec to finish). The result
// appears in the same cycle the block is ready again. Multiply and divide
// run on the shared adder, which produces one product or quotient bit per
// cycle; the stack memory adds one registered read for the lower operand. A
// finished result sits in an output register, so the next word is taken
// while the previous result still waits to be collected. The stack memory
// needs no clearing after reset: only entries below the fill count are used.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit
   import pfx_eval_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [7:0]         req_symbol,
   input  wire                req_last,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status,
   output logic               rsp_done_res
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   // Sequencer and captured word
   state_type        state_ff, state_in;
   logic [7:0]       sym_ff, sym_in;
   logic             last_ff, last_in;

   // Stack bookkeeping
   logic [CW-1:0]    count_ff, count_in;
   status_type       err_ff, err_in;
   logic [31:0]      top_ff, top_in;

   // Shared arithmetic registers: accumulator / remainder, multiplicand /
   // quotient, multiplier / divisor
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      opa_ff, opa_in;
   logic [31:0]      opb_ff, opb_in;
   logic [31:0]      res_ff, res_in;
   logic             neg_ff, neg_in;
   logic [4:0]       step_ff, step_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_value_ff, rsp_value_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_done_ff, rsp_done_in;

   // Stack memory
   logic [31:0]      stack_mem [STACK_DEPTH];
   logic [31:0]      rd_data_ff;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [31:0]      wr_data;

   // Shared adder
   logic [32:0]      alu_a, alu_b, alu_sum;
   logic             alu_sub;

   logic             is_digit, is_oper, accept, out_free, full;
   logic [CW-1:0]    count_m1, count_m2;
   logic [31:0]      op1_abs, op2_abs;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_digit = (sym_ff >= CHAR_ZERO) && (sym_ff <= CHAR_NINE);
   assign is_oper  = (sym_ff == CHAR_PLUS) || (sym_ff == CHAR_MINUS) ||
                     (sym_ff == CHAR_STAR) || (sym_ff == CHAR_SLASH);
   assign full     = (count_ff == CW'(STACK_DEPTH));
   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign rd_addr  = count_m2[AW-1:0];
   assign op1_abs  = rd_data_ff[31] ? (~rd_data_ff + 32'd1) : rd_data_ff;
   assign op2_abs  = top_ff[31] ? (~top_ff + 32'd1) : top_ff;

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = $signed(rsp_value_ff);
   assign rsp_status   = rsp_status_ff;
   assign rsp_done_res = rsp_done_ff;

   // Shared adder: one add or subtract per cycle, operands chosen by state
   always_comb begin
      alu_a   = {1'b0, rd_data_ff};
      alu_b   = {1'b0, top_ff};
      alu_sub = (sym_ff == CHAR_MINUS);
      case (state_ff)
         ST_MUL: begin
            alu_a   = {1'b0, acc_ff};
            alu_b   = {1'b0, opa_ff};
            alu_sub = 1'b0;
         end
         ST_DIV: begin
            alu_a   = {acc_ff, opa_ff[31]};
            alu_b   = {1'b0, opb_ff};
            alu_sub = 1'b1;
         end
         ST_FIX: begin
            alu_a   = 33'd0;
            alu_b   = {1'b0, opa_ff};
            alu_sub = 1'b1;
         end
         default: ;
      endcase
      alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DECODE;
         ST_DECODE: begin
            if (err_ff == STAT_OK && is_oper && count_ff >= CW'(2)) begin
               state_in = ST_EXEC;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_EXEC: begin
            if (sym_ff == CHAR_STAR) begin
               state_in = ST_MUL;
            end else if (sym_ff == CHAR_SLASH) begin
               state_in = (top_ff == 32'd0) ? ST_FINISH : ST_DIV;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_MUL:    if (step_ff == 5'd0) state_in = ST_WRITE;
         ST_DIV: begin
            if (step_ff == 5'd0) state_in = neg_ff ? ST_FIX : ST_WRITE;
         end
         ST_FIX:    state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      sym_in        = sym_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      acc_in        = acc_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      res_in        = res_ff;
      neg_in        = neg_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = {28'd0, sym_ff[3:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sym_in  = req_symbol;
               last_in = req_last;
            end
         end
         ST_DECODE: begin
            // a latched fault freezes the stack
            if (err_ff == STAT_OK) begin
               if (is_digit) begin
                  if (full) begin
                     err_in = STAT_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     top_in   = {28'd0, sym_ff[3:0]};
                     count_in = count_ff + CW'(1);
                  end
               end else if (is_oper) begin
                  if (count_ff < CW'(2)) err_in = STAT_UNDERFLOW;
               end else begin
                  err_in = STAT_INVALID;
               end
            end
         end
         ST_EXEC: begin
            // op1 from memory, op2 is the cached top
            res_in  = alu_sum[31:0];
            acc_in  = 32'd0;
            step_in = 5'd31;
            if (sym_ff == CHAR_STAR) begin
               opa_in = rd_data_ff;
               opb_in = top_ff;
            end else if (sym_ff == CHAR_SLASH) begin
               if (top_ff == 32'd0) err_in = STAT_DIVZERO;
               opa_in = op1_abs;
               opb_in = op2_abs;
               neg_in = rd_data_ff[31] ^ top_ff[31];
            end
         end
         ST_MUL: begin
            // shift-add, one multiplier bit per cycle
            if (opb_ff[0]) acc_in = alu_sum[31:0];
            opa_in  = {opa_ff[30:0], 1'b0};
            opb_in  = {1'b0, opb_ff[31:1]};
            step_in = step_ff - 5'd1;
            res_in  = opb_ff[0] ? alu_sum[31:0] : acc_ff;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (!alu_sum[32]) begin
               acc_in = alu_sum[31:0];
            end else begin
               acc_in = {acc_ff[30:0], opa_ff[31]};
            end
            opa_in  = {opa_ff[30:0], !alu_sum[32]};
            step_in = step_ff - 5'd1;
            res_in  = {opa_ff[30:0], !alu_sum[32]};
         end
         ST_FIX: begin
            res_in = alu_sum[31:0];
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = count_m2[AW-1:0];
            wr_data  = res_ff;
            top_in   = res_ff;
            count_in = count_m1;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (count_ff != '0) ? top_ff : 32'd0;
               rsp_status_in = err_ff;
               if (last_ff && err_ff == STAT_OK && count_ff == '0) begin
                  rsp_status_in = STAT_UNDERFLOW;
               end
               rsp_done_in = last_ff;
               // end of expression: drop the stack and the fault
               if (last_ff) begin
                  count_in = '0;
                  err_in   = STAT_OK;
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         err_ff       <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      top_ff        <= top_in;
      acc_ff        <= acc_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      res_ff        <= res_in;
      neg_ff        <= neg_in;
      step_ff       <= step_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
   end

   // Stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      rd_data_ff <= stack_mem[rd_addr];
   end

   // Assertions
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack fill count beyond depth");

   a_fault_freezes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE && err_ff != STAT_OK) |=> $stable(count_ff))
      else $error("stack changed under a latched fault");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DECODE))
      else $error("accepted word not decoded");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STAT_OK || rsp_status_ff == STAT_OVERFLOW ||
                        rsp_status_ff == STAT_UNDERFLOW || rsp_status_ff == STAT_INVALID ||
                        rsp_status_ff == STAT_DIVZERO))
      else $error("undefined status code");

   a_iter_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && step_ff == 5'd0) |=> (state_ff == ST_WRITE))
      else $error("multiply did not retire after 32 steps");

endmodule
`default_nettype wire
